// ===== rtl/clr_pkg.sv =====
// Shared types and constants of the chord loop recorder.
// Used by clr_cfg, clr_core, the top level, the bench and the output channel interface; depends on nothing.
`default_nettype none

package clr_pkg;

  // Recorder modes as carried on the result channel.
  typedef enum logic [1:0] {
    MODE_PAUSE  = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_t;

  // Input operation codes; code 3 is unused and changes nothing.
  localparam logic [1:0] OP_PRESS = 2'd0;
  localparam logic [1:0] OP_CHORD = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Field widths fixed by the channel definitions.
  localparam int CHORD_BITS         = 8;
  localparam int NOTE_SAMPLES_BITS  = 16;
  localparam int NOTES_PER_BAR_BITS = 7;
  localparam int THR_BITS           = NOTE_SAMPLES_BITS + NOTES_PER_BAR_BITS;

  // Configuration port layout and register indexes.
  localparam int         CFG_IDX_BITS      = 1;
  localparam int         CFG_DATA_BITS     = NOTE_SAMPLES_BITS;
  localparam logic [0:0] CFG_NOTE_SAMPLES  = 1'd0;
  localparam logic [0:0] CFG_NOTES_PER_BAR = 1'd1;

  // Register reset values.
  localparam logic [NOTE_SAMPLES_BITS-1:0]  NOTE_SAMPLES_RESET  = 16'd4096;
  localparam logic [NOTES_PER_BAR_BITS-1:0] NOTES_PER_BAR_RESET = 7'd8;

  // Note steps at the end of a bar that lie beyond the wrap threshold.
  localparam logic [NOTES_PER_BAR_BITS-1:0] WRAP_MARGIN_STEPS = 7'd2;

  // One result beat.
  typedef struct packed {
    mode_t                 mode;
    logic                  show_chords;
    logic [CHORD_BITS-1:0] chord_out;
    logic                  chord_changed;
    logic                  store_full;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/clr_if.sv =====
// Valid/ready channel interfaces for the input items and the result beats.
// The result interface takes its field widths from clr_pkg.
`default_nettype none

interface clr_in_if #(
  parameter int SAMPLE_BITS = 20
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [7:0]             chord;
  logic [SAMPLE_BITS-1:0] sample_pos;

  modport source (output valid, output op, output chord, output sample_pos, input ready);
  modport sink (input valid, input op, input chord, input sample_pos, output ready);
endinterface

interface clr_out_if
  import clr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic                  show_chords;
  logic [CHORD_BITS-1:0] chord_out;
  logic                  chord_changed;
  logic                  store_full;

  modport source (output valid, output mode, output show_chords, output chord_out,
                  output chord_changed, output store_full, input ready);
  modport sink (input valid, input mode, input show_chords, input chord_out,
                input chord_changed, input store_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/clr_cfg.sv =====
// Configuration registers and the wrap threshold derived from them.
// Depends on clr_pkg for register indexes, widths and reset values.
`default_nettype none

module clr_cfg
  import clr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic [THR_BITS-1:0]      thr
);

  logic [NOTE_SAMPLES_BITS-1:0]  note_samples;
  logic [NOTES_PER_BAR_BITS-1:0] notes_per_bar;
  logic [NOTES_PER_BAR_BITS-1:0] wrap_steps;

  // Register writes; there is no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      note_samples  <= NOTE_SAMPLES_RESET;
      notes_per_bar <= NOTES_PER_BAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOTE_SAMPLES:  note_samples  <= cfg_data[NOTE_SAMPLES_BITS-1:0];
        CFG_NOTES_PER_BAR: notes_per_bar <= cfg_data[NOTES_PER_BAR_BITS-1:0];
      endcase
    end
  end

  // The threshold is the sample count of all but the last two note steps.
  // A bar of fewer than two steps gives a threshold of zero.
  always_comb begin
    wrap_steps = (notes_per_bar >= WRAP_MARGIN_STEPS) ? (notes_per_bar - WRAP_MARGIN_STEPS)
                                                      : '0;
    thr = THR_BITS'(note_samples) * THR_BITS'(wrap_steps);
  end

endmodule

`default_nettype wire

// ===== rtl/clr_event_mem.sv =====
// Event store: one write port and one registered read port.
// A read at the address being written returns the new data. No dependencies.
`default_nettype none

module clr_event_mem #(
  parameter int DEPTH      = 256,
  parameter int WIDTH      = 44,
  parameter int ADDR_BITS  = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read with write-first bypass.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clr_core.sv =====
// Recorder state, next-state logic for one item and the event store.
// Depends on clr_pkg and instantiates clr_event_mem.
`default_nettype none

module clr_core
  import clr_pkg::*;
#(
  parameter int EVENT_DEPTH = 256,
  parameter int BAR_BITS    = 16,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [1:0]             op,
  input  logic [CHORD_BITS-1:0]  chord,
  input  logic [SAMPLE_BITS-1:0] sample_pos,
  input  logic [THR_BITS-1:0]    thr,
  output result_t                res
);

  localparam int IDX_BITS   = $clog2(EVENT_DEPTH);
  localparam int CNT_BITS   = $clog2(EVENT_DEPTH + 1);
  localparam int ENTRY_BITS = BAR_BITS + SAMPLE_BITS + CHORD_BITS;
  localparam int CMP_BITS   = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  // Control state.
  mode_t               mode,        mode_next;
  logic [BAR_BITS-1:0] bar_count,   bar_next;
  logic [IDX_BITS-1:0] play_index,  play_index_next;
  logic [CNT_BITS-1:0] event_count, event_count_next;

  // Copies of the last stored event and of the first chord.
  logic [BAR_BITS-1:0]    last_bar,    last_bar_next;
  logic [SAMPLE_BITS-1:0] last_smp,    last_smp_next;
  logic [CHORD_BITS-1:0]  first_chord, first_chord_next;

  // Store access.
  logic                   wr_en;
  logic [IDX_BITS-1:0]    wr_idx;
  logic [BAR_BITS-1:0]    wr_bar;
  logic [SAMPLE_BITS-1:0] wr_smp;
  logic [CHORD_BITS-1:0]  wr_chord;
  logic [IDX_BITS-1:0]    rd_idx;
  logic [ENTRY_BITS-1:0]  rd_entry;
  logic [BAR_BITS-1:0]    rd_bar;
  logic [SAMPLE_BITS-1:0] rd_smp;
  logic [CHORD_BITS-1:0]  rd_chord;

  // Working values.
  logic                   is_full;
  logic                   full;
  logic                   emit;
  logic [CHORD_BITS-1:0]  emit_chord;
  logic [BAR_BITS-1:0]    bar_now;
  logic [IDX_BITS-1:0]    eff_idx;
  logic [CNT_BITS-1:0]    eff_inc;
  logic [CNT_BITS-1:0]    cnt_after;
  logic [IDX_BITS-1:0]    idx_sel;
  logic [CNT_BITS-1:0]    cnt_sel;

  assign {rd_bar, rd_smp, rd_chord} = rd_entry;

  // Next state and result for the item in the input register.
  always_comb begin
    mode_next        = mode;
    bar_next         = bar_count;
    play_index_next  = play_index;
    event_count_next = event_count;
    last_bar_next    = last_bar;
    last_smp_next    = last_smp;
    first_chord_next = first_chord;
    wr_en            = 1'b0;
    wr_idx           = event_count[IDX_BITS-1:0];
    wr_bar           = bar_count;
    wr_smp           = sample_pos;
    wr_chord         = chord;
    full             = 1'b0;
    emit             = 1'b0;
    emit_chord       = '0;
    cnt_after        = event_count;

    is_full = (event_count >= CNT_BITS'(EVENT_DEPTH));
    bar_now = (sample_pos == '0) ? (bar_count + BAR_BITS'(1)) : bar_count;
    eff_idx = (CNT_BITS'(play_index) >= event_count) ? '0 : play_index;
    eff_inc = CNT_BITS'(eff_idx) + CNT_BITS'(1);

    unique case (op)
      OP_PRESS: begin
        unique case (mode)
          MODE_PAUSE: begin
            // Start a fresh take with the current chord at the top of bar zero.
            mode_next        = MODE_RECORD;
            event_count_next = CNT_BITS'(1);
            bar_next         = '0;
            wr_en            = 1'b1;
            wr_idx           = '0;
            wr_bar           = '0;
            wr_smp           = '0;
            last_bar_next    = '0;
            last_smp_next    = '0;
            first_chord_next = chord;
          end
          MODE_RECORD: begin
            // A late last event gets a wrap entry at the top of the next bar.
            mode_next = MODE_PLAY;
            if ((event_count != '0) && (CMP_BITS'(last_smp) > CMP_BITS'(thr))) begin
              if (is_full) begin
                full = 1'b1;
              end else begin
                wr_en         = 1'b1;
                wr_bar        = last_bar + BAR_BITS'(1);
                wr_smp        = '0;
                cnt_after     = event_count + CNT_BITS'(1);
                last_bar_next = last_bar + BAR_BITS'(1);
                last_smp_next = '0;
              end
            end
            event_count_next = cnt_after;
            // Rewind; the first event sits at bar zero, sample zero, so it plays now.
            bar_next        = '0;
            play_index_next = '0;
            if (cnt_after != '0) begin
              emit       = 1'b1;
              emit_chord = first_chord;
              if (cnt_after != CNT_BITS'(1)) begin
                play_index_next = IDX_BITS'(1);
              end
            end
          end
          default: begin
            mode_next = MODE_PAUSE;
          end
        endcase
      end
      OP_CHORD: begin
        // Chord changes are stored only while recording.
        if (mode == MODE_RECORD) begin
          if (is_full) begin
            full = 1'b1;
          end else begin
            wr_en            = 1'b1;
            event_count_next = event_count + CNT_BITS'(1);
            last_bar_next    = bar_count;
            last_smp_next    = sample_pos;
          end
        end
      end
      OP_TICK: begin
        bar_next = bar_now;
        if ((mode == MODE_PLAY) && (event_count != '0)) begin
          play_index_next = eff_idx;
          if ((bar_now >= rd_bar) && (sample_pos >= rd_smp)) begin
            emit       = 1'b1;
            emit_chord = rd_chord;
            if (eff_inc == event_count) begin
              bar_next        = '0;
              play_index_next = '0;
            end else begin
              play_index_next = eff_inc[IDX_BITS-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.mode          = mode_next;
    res.show_chords   = (mode_next != MODE_PLAY);
    res.chord_out     = emit ? emit_chord : '0;
    res.chord_changed = emit;
    res.store_full    = full;

    // Fetch the entry that the next tick will compare against.
    idx_sel = go ? play_index_next : play_index;
    cnt_sel = go ? event_count_next : event_count;
    rd_idx  = (CNT_BITS'(idx_sel) >= cnt_sel) ? '0 : idx_sel;
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PAUSE;
      bar_count   <= '0;
      play_index  <= '0;
      event_count <= '0;
    end else if (go) begin
      mode        <= mode_next;
      bar_count   <= bar_next;
      play_index  <= play_index_next;
      event_count <= event_count_next;
    end
  end

  // Event copies; only read once the matching event exists.
  always_ff @(posedge clk) begin
    if (go) begin
      last_bar    <= last_bar_next;
      last_smp    <= last_smp_next;
      first_chord <= first_chord_next;
    end
  end

  clr_event_mem #(
    .DEPTH     (EVENT_DEPTH),
    .WIDTH     (ENTRY_BITS),
    .ADDR_BITS (IDX_BITS)
  ) u_event_mem (
    .clk   (clk),
    .we    (go && wr_en),
    .waddr (wr_idx),
    .wdata ({wr_bar, wr_smp, wr_chord}),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

endmodule

`default_nettype wire

// ===== rtl/chord_loop_recorder.sv =====
// Top level of the chord loop recorder: input register, core and result register.
// Depends on clr_pkg, clr_if, clr_cfg and clr_core.
//
// Usage. Items arrive on the din channel (op, chord, sample_pos) and every item
// gives exactly one result beat on the dout channel (mode, show_chords,
// chord_out, chord_changed, store_full). A beat moves at a rising clock edge
// where valid and ready are both high. The two configuration registers are to be
// written through cfg_we, cfg_index and cfg_data only while no item is in flight;
// the block itself does not enforce this. A taken item waits in the input
// register; once the result register is free or being drained, the state update
// and the event store compare run and the result register loads its beat for dout.
// Throughput: one item per cycle while the receiver does not stall. The event store
// has one read port whose data are registered; it holds the entry of the next
// playback event ready.
// Reset (rst, synchronous) puts the recorder in pause with an empty store and
// the registers at their default values; no clearing pass is needed.
// When the receiver stalls, the result register holds its beat and the input
// register still accepts one more item; after that din.ready drops.
`default_nettype none

module chord_loop_recorder
  import clr_pkg::*;
#(
  parameter int EVENT_DEPTH = 256,
  parameter int BAR_BITS    = 16,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  clr_in_if.sink                   din,
  clr_out_if.source                dout
);

  logic                   in_valid;
  logic [1:0]             in_op;
  logic [CHORD_BITS-1:0]  in_chord;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic                   go;
  logic                   out_valid;
  result_t                res;
  result_t                res_next;
  logic [THR_BITS-1:0]    thr;

  // The held item advances when the result register is free or being drained.
  assign go        = in_valid && (!out_valid || dout.ready);
  assign din.ready = !in_valid || go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.ready) begin
      in_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      in_op    <= din.op;
      in_chord <= din.chord;
      in_smp   <= din.sample_pos;
    end
  end

  clr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  clr_core #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .BAR_BITS    (BAR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .op         (in_op),
    .chord      (in_chord),
    .sample_pos (in_smp),
    .thr        (thr),
    .res        (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= res_next;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.mode          = res.mode;
  assign dout.show_chords   = res.show_chords;
  assign dout.chord_out     = res.chord_out;
  assign dout.chord_changed = res.chord_changed;
  assign dout.store_full    = res.store_full;

endmodule

`default_nettype wire

// ===== bench/chord_loop_recorder_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the chord loop recorder: directed and random item streams.
// Depends on clr_pkg, the channel interfaces in clr_if and the chord_loop_recorder top level.

module chord_loop_recorder_test;
  import clr_pkg::*;

  localparam int EVENT_DEPTH = 256;
  localparam int BAR_BITS    = 16;
  localparam int SAMPLE_BITS = 20;

  localparam int unsigned SMP_MAX = (1 << SAMPLE_BITS) - 1;

  // The fourth operation code has no meaning and must leave the state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [CHORD_BITS-1:0]  chord;
    logic [SAMPLE_BITS-1:0] sample_pos;
  } item_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  clr_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) din_ch ();
  clr_out_if dout_ch ();

  chord_loop_recorder #(
    .EVENT_DEPTH(EVENT_DEPTH),
    .BAR_BITS   (BAR_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .din      (din_ch.sink),
    .dout     (dout_ch.source)
  );

  // Bench copy of the recorder state and of its two registers.
  mode_t                         rec_mode;
  logic [BAR_BITS-1:0]           bar_now;
  int unsigned                   play_pos;
  int unsigned                   event_total;
  logic [BAR_BITS-1:0]           take_bar   [EVENT_DEPTH];
  logic [SAMPLE_BITS-1:0]        take_smp   [EVENT_DEPTH];
  logic [CHORD_BITS-1:0]         take_chord [EVENT_DEPTH];
  logic [NOTE_SAMPLES_BITS-1:0]  note_samples_cfg;
  logic [NOTES_PER_BAR_BITS-1:0] notes_per_bar_cfg;

  item_t       pending_items[$];
  result_t     expected_beats[$];
  item_t       offered_item;
  mode_t       script_mode;
  int unsigned items_made;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned hold_left;
  int unsigned fault_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Append one event to the take; returns 1 when the store is already full.
  function automatic logic store_event(input logic [BAR_BITS-1:0] bar,
                                       input logic [SAMPLE_BITS-1:0] smp,
                                       input logic [CHORD_BITS-1:0] chord);
    if (event_total >= EVENT_DEPTH) return 1'b1;
    take_bar[event_total]   = bar;
    take_smp[event_total]   = smp;
    take_chord[event_total] = chord;
    event_total++;
    return 1'b0;
  endfunction

  // Play the next stored chord once its bar and sample position are reached.
  function automatic logic play_event(input logic [SAMPLE_BITS-1:0] smp,
                                      output logic [CHORD_BITS-1:0] chord);
    chord = '0;
    if (event_total == 0) return 1'b0;
    if (play_pos >= event_total) play_pos = 0;
    if (bar_now >= take_bar[play_pos] && smp >= take_smp[play_pos]) begin
      chord = take_chord[play_pos];
      play_pos++;
      if (play_pos == event_total) begin
        bar_now  = '0;
        play_pos = 0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the bench state by one item and return the beat it must produce.
  function automatic result_t next_recorder_beat(input item_t it);
    result_t               beat;
    logic [CHORD_BITS-1:0] played;
    logic                  hit;
    logic                  dropped;
    int unsigned           last;
    int unsigned           steps;
    int unsigned           threshold;
    played  = '0;
    hit     = 1'b0;
    dropped = 1'b0;
    case (it.op)
      OP_PRESS: begin
        rec_mode = (rec_mode >= MODE_PLAY) ? MODE_PAUSE : mode_t'(rec_mode + 1'b1);
        if (rec_mode == MODE_RECORD) begin
          event_total = 0;
          bar_now     = '0;
          dropped     = store_event('0, '0, it.chord);
        end else if (rec_mode == MODE_PLAY) begin
          // A last event late in its bar gets a wrap entry at the start of the next bar.
          if (event_total > 0) begin
            last      = event_total - 1;
            steps     = (notes_per_bar_cfg >= 2) ? notes_per_bar_cfg - 2 : 0;
            threshold = note_samples_cfg * steps;
            if (take_smp[last] > threshold)
              dropped = store_event(take_bar[last] + 1'b1, '0, it.chord);
          end
          play_pos = 0;
          bar_now  = '0;
          hit      = play_event(it.sample_pos, played);
        end
      end
      OP_CHORD: begin
        if (rec_mode == MODE_RECORD) dropped = store_event(bar_now, it.sample_pos, it.chord);
      end
      OP_TICK: begin
        if (it.sample_pos == '0) bar_now = bar_now + 1'b1;
        if (rec_mode == MODE_PLAY) hit = play_event(it.sample_pos, played);
      end
      default: begin
      end
    endcase
    beat.mode          = rec_mode;
    beat.show_chords   = (rec_mode != MODE_PLAY);
    beat.chord_out     = hit ? played : '0;
    beat.chord_changed = hit;
    beat.store_full    = dropped;
    return beat;
  endfunction

  // Input driver: one beat offered at a time, with random gaps outside a calm window.
  always @(posedge clk) begin : drive_items
    logic offer;
    if (rst) begin
      din_ch.valid <= 1'b0;
    end else begin
      if (din_ch.valid && din_ch.ready) begin
        expected_beats = {expected_beats, next_recorder_beat(offered_item)};
        items_taken++;
      end
      if (!din_ch.valid || din_ch.ready) begin
        offer = (pending_items.size() != 0) &&
                ((items_taken >= 600 && items_taken < 900) || $urandom_range(0, 99) >= 21);
        if (offer) begin
          offered_item = pending_items.pop_front();
          din_ch.op         <= offered_item.op;
          din_ch.chord      <= offered_item.chord;
          din_ch.sample_pos <= offered_item.sample_pos;
        end
        din_ch.valid <= offer;
      end
    end
  end

  // Result monitor: compares every beat with the oldest expectation and drives ready.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      dout_ch.ready <= 1'b0;
    end else begin
      if (dout_ch.valid && dout_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat arrived with nothing expected");
          fault_count++;
        end else begin
          want = expected_beats.pop_front();
          if (dout_ch.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, dout_ch.mode);
            fault_count++;
          end
          if (dout_ch.show_chords !== want.show_chords) begin
            $error("show_chords: expected %0d, got %0d", want.show_chords,
                   dout_ch.show_chords);
            fault_count++;
          end
          if (dout_ch.chord_out !== want.chord_out) begin
            $error("chord_out: expected %0d, got %0d", want.chord_out, dout_ch.chord_out);
            fault_count++;
          end
          if (dout_ch.chord_changed !== want.chord_changed) begin
            $error("chord_changed: expected %0d, got %0d", want.chord_changed,
                   dout_ch.chord_changed);
            fault_count++;
          end
          if (dout_ch.store_full !== want.store_full) begin
            $error("store_full: expected %0d, got %0d", want.store_full,
                   dout_ch.store_full);
            fault_count++;
          end
        end
        results_seen++;
        // Long back-pressure so that the block fills up and stalls its input.
        if (results_seen == 350 || results_seen == 1200) hold_left = 120;
      end
      if (hold_left != 0) begin
        hold_left--;
        dout_ch.ready <= 1'b0;
      end else begin
        dout_ch.ready <= (results_seen >= 600 && results_seen < 900) ||
                         $urandom_range(0, 99) >= 21;
      end
    end
  end

  function automatic logic [CHORD_BITS-1:0] rand_chord();
    return CHORD_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_smp();
    return SAMPLE_BITS'($urandom_range(0, SMP_MAX));
  endfunction

  // Queue one item and keep track of the mode it leads to.
  task automatic add_item(input logic [1:0] op, input logic [CHORD_BITS-1:0] chord,
                          input logic [SAMPLE_BITS-1:0] smp);
    item_t it;
    it.op         = op;
    it.chord      = chord;
    it.sample_pos = smp;
    pending_items = {pending_items, it};
    if (op == OP_PRESS)
      script_mode = (script_mode >= MODE_PLAY) ? MODE_PAUSE : mode_t'(script_mode + 1'b1);
    items_made++;
  endtask

  // Now and then a stray item of any kind, presses among them.
  task automatic add_noise();
    int unsigned pick;
    if ($urandom_range(0, 99) < 8) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      add_item(OP_PRESS, rand_chord(), rand_smp());
      else if (pick <= 3) add_item(OP_CHORD, rand_chord(), rand_smp());
      else if (pick <= 6) add_item(OP_TICK, rand_chord(), rand_smp());
      else                add_item(OP_UNUSED, rand_chord(), rand_smp());
    end
  endtask

  task automatic to_pause();
    while (script_mode != MODE_PAUSE) add_item(OP_PRESS, rand_chord(), rand_smp());
  endtask

  // Bars as a sequencer plays them: a tick at sample 0, then rising positions.
  task automatic run_bars(input int bars, input int unsigned span, input int chord_pct);
    int unsigned steps_in_bar;
    int unsigned stride;
    int unsigned pos;
    for (int b = 0; b < bars; b++) begin
      steps_in_bar = $urandom_range(2, 6);
      stride       = (span / steps_in_bar > 0) ? span / steps_in_bar : 1;
      for (int i = 0; i < steps_in_bar; i++) begin
        pos = (i == 0) ? 0 : i * stride + $urandom_range(0, stride - 1);
        if (pos > SMP_MAX) pos = SMP_MAX;
        add_item(OP_TICK, rand_chord(), SAMPLE_BITS'(pos));
        if ($urandom_range(0, 99) < chord_pct)
          add_item(OP_CHORD, rand_chord(), SAMPLE_BITS'(pos));
        add_noise();
      end
    end
  endtask

  // One take: record a few bars, play them back a couple of times, then pause.
  task automatic loop_take(input int bars);
    int unsigned threshold;
    int unsigned span;
    threshold = note_samples_cfg *
                ((notes_per_bar_cfg >= 2) ? notes_per_bar_cfg - 2 : 0);
    case ($urandom_range(0, 3))
      0, 1:    span = threshold + threshold / 3 + 16;
      2:       span = SMP_MAX;
      default: span = $urandom_range(4, 2000);
    endcase
    if (span > SMP_MAX) span = SMP_MAX;
    to_pause();
    add_item(OP_PRESS, rand_chord(), rand_smp());
    run_bars(bars, span, 45);
    add_item(OP_PRESS, rand_chord(), ($urandom_range(0, 1) != 0) ? '0 : rand_smp());
    run_bars(2 * bars + 1, span, 5);
    add_item(OP_PRESS, rand_chord(), rand_smp());
  endtask

  // A take whose chord changes, with its first event, fill the store or overflow it; the last one lies late in its bar.
  task automatic fill_take(input int chords);
    to_pause();
    add_item(OP_PRESS, rand_chord(), rand_smp());
    for (int i = 0; i < chords; i++) begin
      if ($urandom_range(0, 99) < 10)
        add_item(OP_TICK, rand_chord(), ($urandom_range(0, 1) != 0) ? '0 : rand_smp());
      add_item(OP_CHORD, rand_chord(), (i == chords - 1) ? SAMPLE_BITS'(SMP_MAX) : rand_smp());
    end
    add_item(OP_PRESS, rand_chord(), '0);
    run_bars(3, SMP_MAX, 0);
    add_item(OP_PRESS, rand_chord(), rand_smp());
  endtask

  // Register writes, only while nothing is in flight.
  task automatic set_config(input logic [NOTE_SAMPLES_BITS-1:0] ns,
                            input logic [NOTES_PER_BAR_BITS-1:0] npb);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NOTE_SAMPLES;
    cfg_data  <= CFG_DATA_BITS'(ns);
    @(posedge clk);
    cfg_index <= CFG_NOTES_PER_BAR;
    cfg_data  <= CFG_DATA_BITS'(npb);
    @(posedge clk);
    cfg_we <= 1'b0;
    note_samples_cfg  = ns;
    notes_per_bar_cfg = npb;
    @(negedge clk);
  endtask

  // Wait until every queued item has been taken and its beat checked.
  task automatic drain();
    while (pending_items.size() != 0 || din_ch.valid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_NOTE_SAMPLES;
    cfg_data          = '0;
    din_ch.valid      = 1'b0;
    din_ch.op         = OP_TICK;
    din_ch.chord      = '0;
    din_ch.sample_pos = '0;
    dout_ch.ready     = 1'b0;
    rec_mode          = MODE_PAUSE;
    script_mode       = MODE_PAUSE;
    bar_now           = '0;
    play_pos          = 0;
    event_total       = 0;
    note_samples_cfg  = NOTE_SAMPLES_RESET;
    notes_per_bar_cfg = NOTES_PER_BAR_RESET;
    items_made        = 0;
    items_taken       = 0;
    results_seen      = 0;
    hold_left         = 0;
    fault_count       = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening with the registers at their reset values.
    add_item(OP_TICK, 8'hFF, '0);                     // bar advance in pause
    add_item(OP_CHORD, 8'hFF, SAMPLE_BITS'(SMP_MAX)); // chord change outside record
    add_item(OP_UNUSED, 8'hAA, 20'h55555);
    add_item(OP_PRESS, 8'hFF, 20'h0F0F0);             // into record, first event
    add_item(OP_CHORD, 8'h00, '0);
    add_item(OP_TICK, 8'h00, '0);                     // bar 1
    add_item(OP_CHORD, 8'h5A, SAMPLE_BITS'(SMP_MAX)); // late in the bar
    add_item(OP_UNUSED, 8'h55, SAMPLE_BITS'(SMP_MAX));
    add_item(OP_PRESS, 8'h33, '0);                    // into play with a wrap entry
    add_item(OP_TICK, 8'h12, '0);
    add_item(OP_TICK, 8'h34, SAMPLE_BITS'(SMP_MAX));
    add_item(OP_TICK, 8'h56, '0);                     // wrap entry, loop rewinds
    add_item(OP_CHORD, 8'hC3, 20'hAAAAA);             // ignored while playing
    add_item(OP_UNUSED, 8'h3C, '0);
    add_item(OP_TICK, 8'h78, 20'h12345);
    add_item(OP_PRESS, 8'h00, '0);                    // back to pause
    add_item(OP_TICK, 8'hFF, '0);

    while (items_made < 220) loop_take($urandom_range(1, 4));
    fill_take(255);
    fill_take(300);
    drain();

    // Extremes of the note sample register, and a bar setting too small to leave a margin.
    set_config(16'd1, 7'd2);
    while (items_made < 1030) loop_take($urandom_range(1, 4));
    drain();
    set_config(16'd65535, 7'd64);
    while (items_made < 1200) loop_take($urandom_range(1, 4));
    drain();
    set_config(16'd65535, 7'd1);
    while (items_made < 1330) loop_take($urandom_range(1, 4));
    drain();
    set_config(16'd300, 7'd3);
    while (items_made < 1400) loop_take($urandom_range(1, 4));
    drain();
    repeat (3) begin
      set_config(NOTE_SAMPLES_BITS'($urandom_range(1, 65535)),
                 NOTES_PER_BAR_BITS'($urandom_range(2, 64)));
      loop_take($urandom_range(1, 4));
      drain();
    end

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
